### src/csf_pkg.sv
// Shared constants, operation codes and the row-scan result type for the
// circular page successor finder. No dependencies.
package csf_pkg;

	// Fixed field widths.
	localparam int PAGE_W = 10;
	localparam int OP_W   = 3;

	// Maps are stored as rows of WORD_W bits; one row is scanned per cycle.
	localparam int WORD_W = 16;
	localparam int BIT_W  = 4;

	// Default page space.
	localparam int DEF_PAGE_SPACE = 1024;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
	localparam logic [OP_W-1:0] OP_NEXT_PAGE = 3'd1;
	localparam logic [OP_W-1:0] OP_PREV_PAGE = 3'd2;
	localparam logic [OP_W-1:0] OP_NEXT_ART  = 3'd3;
	localparam logic [OP_W-1:0] OP_PREV_ART  = 3'd4;

	// Summary of one map row as seen by the scan unit.
	typedef struct packed {
		logic             any;     // row holds at least one member
		logic [BIT_W-1:0] lo_bit;  // lowest member in the row
		logic [BIT_W-1:0] hi_bit;  // highest member in the row
		logic             up_hit;  // some member lies above the reference
		logic [BIT_W-1:0] up_bit;  // lowest such member
		logic             dn_hit;  // some member lies below the reference
		logic [BIT_W-1:0] dn_bit;  // highest such member
	} scan_row_t;

endpackage

### src/csf_map_mem.sv
// Row memory for the present and article-start maps, with per-row valid bits
// so that the maps read as empty right after reset. No dependencies.
module csf_map_mem #(
	parameter int NUM_ROWS = 64,
	parameter int ROW_W    = 6,
	parameter int DATA_W   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ROW_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ROW_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data
);
	logic [DATA_W-1:0]   mem [NUM_ROWS];
	logic [DATA_W-1:0]   rd_data_q;
	logic [NUM_ROWS-1:0] row_valid_q;
	logic                rd_live_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Row valid bits: a row never written reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_live_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			rd_live_q <= row_valid_q[rd_addr];
		end
	end

	assign rd_data = rd_live_q ? rd_data_q : '0;

endmodule

### src/csf_row_scan.sv
// Shared compare and priority unit: summarizes one map row against the
// reference page number. Depends on csf_pkg.
module csf_row_scan #(
	parameter int ROW_W = 6,
	parameter int CMP_W = 10
) (
	input  logic [csf_pkg::WORD_W-1:0] word,
	input  logic [ROW_W-1:0]           row,
	input  logic [CMP_W-1:0]           ref_num,
	output csf_pkg::scan_row_t         summary
);
	import csf_pkg::*;

	localparam int IDX_W = ROW_W + BIT_W;

	logic [WORD_W-1:0] above;
	logic [WORD_W-1:0] below;

	// Per-bit compare of the global page index against the reference.
	always_comb begin
		logic [IDX_W-1:0] idx;
		logic [CMP_W-1:0] idx_ext;
		above = '0;
		below = '0;
		for (int b = 0; b < WORD_W; b++) begin
			idx     = {row, BIT_W'(b)};
			idx_ext = CMP_W'(idx);
			above[b] = word[b] && (idx_ext > ref_num);
			below[b] = word[b] && (idx_ext < ref_num);
		end
	end

	// Priority encoders over the row.
	always_comb begin
		summary = '0;
		summary.any    = |word;
		summary.up_hit = |above;
		summary.dn_hit = |below;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (word[b]) begin
				summary.lo_bit = BIT_W'(b);
			end
			if (above[b]) begin
				summary.up_bit = BIT_W'(b);
			end
		end
		for (int b = 0; b < WORD_W; b++) begin
			if (word[b]) begin
				summary.hi_bit = BIT_W'(b);
			end
			if (below[b]) begin
				summary.dn_bit = BIT_W'(b);
			end
		end
	end

endmodule

### src/circular_page_successor_finder.sv
// Circular page successor finder. Keeps present pages and article starts as
// bit maps stored in 16-bit rows, plus a per-page article flag and first page.
// An insert reads, modifies and writes one map row. For a next or previous
// query the sequencer walks every map row through the single read port of
// the map memory, one row per cycle, into one shared compare and priority
// unit; an in-range previous-article query first reads its own page. Unused
// operation codes go straight to the response state. The block
// takes one word at a time and is not ready while a word is in work. Maps read
// empty immediately after reset through per-row valid bits; there is no
// clearing pass. PAGE_SPACE must be a multiple of 16.
module circular_page_successor_finder #(
	parameter int PAGE_SPACE = csf_pkg::DEF_PAGE_SPACE
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [csf_pkg::OP_W-1:0]   op,
	input  logic [csf_pkg::PAGE_W-1:0] page_number,
	input  logic                       is_article,
	input  logic [csf_pkg::PAGE_W-1:0] article_first,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [csf_pkg::PAGE_W-1:0] result_page,
	output logic                       set_empty
);
	import csf_pkg::*;

	localparam int NUM_ROWS = PAGE_SPACE / WORD_W;
	localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int IDX_W    = ROW_W + BIT_W;
	localparam int CMP_W    = (IDX_W > PAGE_W) ? IDX_W : PAGE_W;
	localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(NUM_ROWS - 1);
	localparam logic [CMP_W:0]   SPACE_LIM = (CMP_W + 1)'(PAGE_SPACE);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_PA_RD,
		S_PA_CHK,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [PAGE_W-1:0] num_q;
	logic              art_q;
	logic [PAGE_W-1:0] first_q;
	logic [PAGE_W-1:0] ref_q;
	logic              up_q;
	logic              sel_start_q;
	logic              use_scan_q;
	logic [ROW_W-1:0]  issue_row_q;
	logic              issue_done_q;
	logic              live_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              any_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic              near_hit_q;
	logic [IDX_W-1:0]  near_q;
	logic              rsp_valid_q;
	logic [PAGE_W-1:0] result_page_q;
	logic              set_empty_q;

	// Article flag and first page per page.
	logic [PAGE_W:0]   art_mem [PAGE_SPACE];
	logic [PAGE_W:0]   art_rd_q;

	// Index forms of the page number.
	logic [CMP_W-1:0]    num_ext;
	logic [IDX_W-1:0]    num_idx;
	logic [ROW_W-1:0]    num_row;
	logic [BIT_W-1:0]    num_bit;
	logic                req_in_range;
	logic [CMP_W-1:0]    req_ext;

	assign num_ext      = CMP_W'(num_q);
	assign num_idx      = num_ext[IDX_W-1:0];
	assign num_row      = num_idx[IDX_W-1:BIT_W];
	assign num_bit      = num_idx[BIT_W-1:0];
	assign req_ext      = CMP_W'(page_number);
	assign req_in_range = {1'b0, req_ext} < SPACE_LIM;

	// Map memory port control.
	logic [ROW_W-1:0]    map_rd_addr;
	logic [2*WORD_W-1:0] map_rd_data;
	logic                map_wr_en;
	logic [2*WORD_W-1:0] map_wr_data;

	assign map_rd_addr = (state_q == S_SCAN) ? issue_row_q : num_row;
	assign map_wr_en   = (state_q == S_INS_WR);

	// Row update for an insert: set the present bit, set or clear the start bit.
	always_comb begin
		map_wr_data = map_rd_data;
		map_wr_data[{1'b0, num_bit}] = 1'b1;
		map_wr_data[{1'b1, num_bit}] = art_q && (first_q == num_q);
	end

	csf_map_mem #(
		.NUM_ROWS(NUM_ROWS),
		.ROW_W   (ROW_W),
		.DATA_W  (2 * WORD_W)
	) u_map_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(map_rd_addr),
		.rd_data(map_rd_data),
		.wr_en  (map_wr_en),
		.wr_addr(num_row),
		.wr_data(map_wr_data)
	);

	// Article store, read at the current page number.
	always_ff @(posedge clk) begin
		if (state_q == S_INS_WR) begin
			art_mem[num_idx] <= {art_q, first_q};
		end
		art_rd_q <= art_mem[num_idx];
	end

	// Shared row scan unit.
	logic [WORD_W-1:0] scan_word;
	scan_row_t         row_sum;

	assign scan_word = sel_start_q ? map_rd_data[2*WORD_W-1:WORD_W] : map_rd_data[WORD_W-1:0];

	csf_row_scan #(
		.ROW_W(ROW_W),
		.CMP_W(CMP_W)
	) u_row_scan (
		.word   (scan_word),
		.row    (row_s1),
		.ref_num(CMP_W'(ref_q)),
		.summary(row_sum)
	);

	// Final answer of a scan, from the accumulated row summaries.
	logic [IDX_W-1:0]  scan_idx;
	logic [CMP_W-1:0]  scan_ext;
	logic [PAGE_W-1:0] scan_page;

	always_comb begin
		if (near_hit_q) begin
			scan_idx = near_q;
		end else if (up_q) begin
			scan_idx = lo_q;
		end else begin
			scan_idx = hi_q;
		end
	end

	assign scan_ext  = CMP_W'(scan_idx);
	assign scan_page = scan_ext[PAGE_W-1:0];

	// Sequencer, scan accumulators and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			num_q         <= '0;
			art_q         <= 1'b0;
			first_q       <= '0;
			ref_q         <= '0;
			up_q          <= 1'b0;
			sel_start_q   <= 1'b0;
			use_scan_q    <= 1'b0;
			issue_row_q   <= '0;
			issue_done_q  <= 1'b0;
			live_s1       <= 1'b0;
			row_s1        <= '0;
			any_q         <= 1'b0;
			lo_q          <= '0;
			hi_q          <= '0;
			near_hit_q    <= 1'b0;
			near_q        <= '0;
			rsp_valid_q   <= 1'b0;
			result_page_q <= '0;
			set_empty_q   <= 1'b0;
		end else begin
			live_s1 <= (state_q == S_SCAN) && !issue_done_q;
			row_s1  <= issue_row_q;

			// The response state reloads the register itself when the old word leaves.
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						num_q        <= page_number;
						art_q        <= is_article;
						first_q      <= article_first;
						ref_q        <= page_number;
						use_scan_q   <= 1'b0;
						issue_row_q  <= '0;
						issue_done_q <= 1'b0;
						any_q        <= 1'b0;
						near_hit_q   <= 1'b0;
						up_q         <= (op == OP_NEXT_PAGE) || (op == OP_NEXT_ART);
						sel_start_q  <= (op == OP_NEXT_ART) || (op == OP_PREV_ART);
						case (op)
							OP_INSERT: begin
								state_q <= req_in_range ? S_INS_RD : S_DONE;
							end
							OP_NEXT_PAGE, OP_PREV_PAGE, OP_NEXT_ART: begin
								use_scan_q <= 1'b1;
								state_q    <= S_SCAN;
							end
							OP_PREV_ART: begin
								use_scan_q <= 1'b1;
								state_q    <= req_in_range ? S_PA_RD : S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_WR;
				end
				S_INS_WR: begin
					state_q <= S_DONE;
				end
				S_PA_RD: begin
					state_q <= S_PA_CHK;
				end
				S_PA_CHK: begin
					// A present article page searches from its article's first page.
					if (map_rd_data[{1'b0, num_bit}] && art_rd_q[PAGE_W]) begin
						ref_q <= art_rd_q[PAGE_W-1:0];
					end
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!issue_done_q) begin
						if (issue_row_q == LAST_ROW) begin
							issue_done_q <= 1'b1;
						end else begin
							issue_row_q <= issue_row_q + 1'b1;
						end
					end
					if (live_s1) begin
						if (row_sum.any) begin
							if (!any_q) begin
								lo_q <= {row_s1, row_sum.lo_bit};
							end
							any_q <= 1'b1;
							hi_q  <= {row_s1, row_sum.hi_bit};
						end
						if (up_q) begin
							if (row_sum.up_hit && !near_hit_q) begin
								near_hit_q <= 1'b1;
								near_q     <= {row_s1, row_sum.up_bit};
							end
						end else if (row_sum.dn_hit) begin
							near_hit_q <= 1'b1;
							near_q     <= {row_s1, row_sum.dn_bit};
						end
						if (row_s1 == LAST_ROW) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						if (use_scan_q && any_q) begin
							result_page_q <= scan_page;
							set_empty_q   <= 1'b0;
						end else begin
							result_page_q <= num_q;
							set_empty_q   <= use_scan_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign result_page = result_page_q;
	assign set_empty   = set_empty_q;

	// A scan leaves for the response state right after its last row.
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && live_s1 && row_s1 == LAST_ROW) |=> (state_q == S_DONE))
		else $error("scan did not finish after last row");

	// An insert writes its row exactly once and then answers.
	a_insert_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR) |=> (state_q == S_DONE))
		else $error("insert write not followed by response");

	// An empty flag is only reported when the scan found no member.
	a_empty_means_none: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) && set_empty_q |-> !any_q && use_scan_q)
		else $error("empty flag raised although members were found");

	// Row data is only consumed while scanning.
	a_live_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		live_s1 |-> (state_q == S_SCAN))
		else $error("scan pipeline active outside scan state");

	// After a word is accepted the block stays busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("ready held high after accepting a word");

endmodule
